/* sv/uv_pkg.sv */
package uv_pkg;

    typedef enum logic [4:0] {
        ST_SCHEME_FIRST  = 5'd0,
        ST_SCHEME        = 5'd1,
        ST_AFTER_COLON   = 5'd2,
        ST_SLASH1        = 5'd3,
        ST_AUTH_START    = 5'd4,
        ST_AUTH_PRE      = 5'd5,
        ST_AUTH_PRE_PORT = 5'd6,
        ST_AUTH_PRE_BAD  = 5'd7,
        ST_HOST_START    = 5'd8,
        ST_HOST_REG      = 5'd9,
        ST_PORT          = 5'd10,
        ST_V6_START      = 5'd11,
        ST_V6_LEAD       = 5'd12,
        ST_V6_GROUP      = 5'd13,
        ST_V6_COLON      = 5'd14,
        ST_V6_ELIDED     = 5'd15,
        ST_V6_V4         = 5'd16,
        ST_FUT_V         = 5'd17,
        ST_FUT_HEX       = 5'd18,
        ST_FUT_DOT       = 5'd19,
        ST_FUT_BODY      = 5'd20,
        ST_IP_CLOSE      = 5'd21,
        ST_PATH          = 5'd22,
        ST_QUERY         = 5'd23,
        ST_FRAG          = 5'd24
    } gstate_t;

    localparam logic [1:0] PCT_NONE = 2'd0;
    localparam logic [1:0] PCT_TWO  = 2'd1;
    localparam logic [1:0] PCT_ONE  = 2'd2;

    localparam logic [3:0] OCT_EMPTY = 4'd0;
    localparam logic [3:0] OCT_BAD   = 4'd10;

    typedef struct packed {
        logic alpha;
        logic digit;
        logic hex;
        logic unres;
        logic sub;
    } cclass_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] chr;
        cclass_t    cls;
    } citem_t;

    function automatic cclass_t classify(input logic [7:0] c);
        cclass_t r;
        r.alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        r.digit = (c >= "0" && c <= "9");
        r.hex   = r.digit || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        r.unres = r.alpha || r.digit || c == "-" || c == "." || c == "_" || c == "~";
        r.sub   = c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
                  c == "*" || c == "+" || c == "," || c == ";" || c == "=";
        return r;
    endfunction

endpackage

/* sv/uv_class_cell.sv */
module uv_class_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [7:0]     in_chr,
    input  logic           in_last,
    output uv_pkg::citem_t out_item
);
    import uv_pkg::*;

    citem_t item_reg;

    // classify the byte and hand it to the grammar cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg.valid <= in_valid;
        end
        if (en) begin
            item_reg.last <= in_last;
            item_reg.chr  <= in_chr;
            item_reg.cls  <= classify(in_chr);
        end
    end

    assign out_item = item_reg;
endmodule

/* sv/uv_step_cell.sv */
module uv_step_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  uv_pkg::citem_t in_item,
    output logic           res_fire,
    output logic           res_ok
);
    import uv_pkg::*;

    gstate_t    base_reg, base_next;
    logic [1:0] pct_reg, pct_next;
    logic [3:0] grp_reg, grp_next;
    logic [2:0] dig_reg, dig_next;
    logic       eli_reg, eli_next;
    logic [3:0] oct_reg, oct_next;
    logic       rej_reg, rej_next;

    gstate_t    sb;
    logic [1:0] sp;
    logic [3:0] sg;
    logic [2:0] sd;
    logic       se;
    logic [3:0] so;
    logic       good;
    logic       acc;

    function automatic logic [3:0] oct_step(input logic [3:0] o, input logic [7:0] c);
        logic [3:0] d;
        d = c[3:0];
        if (!(c >= "0" && c <= "9")) return OCT_BAD;
        unique case (o)
            4'd0:                return (d == 4'd0) ? 4'd1 : (d == 4'd1) ? 4'd2 :
                                        (d == 4'd2) ? 4'd3 : 4'd4;
            4'd2:                return 4'd5;
            4'd3:                return (d < 4'd5) ? 4'd6 : (d == 4'd5) ? 4'd7 : 4'd8;
            4'd4, 4'd5, 4'd6:    return 4'd9;
            4'd7:                return (d <= 4'd5) ? 4'd9 : OCT_BAD;
            default:             return OCT_BAD;
        endcase
    endfunction

    // grammar step for one byte
    always_comb begin
        logic [7:0] c;
        cclass_t    k;
        logic       pch;
        logic       endf;
        gstate_t    ends;
        c    = in_item.chr;
        k    = in_item.cls;
        pch  = k.unres || k.sub || c == ":" || c == "@";
        endf = c == "/" || c == "?" || c == "#";
        ends = (c == "/") ? ST_PATH : (c == "?") ? ST_QUERY : ST_FRAG;
        sb = base_reg; sp = pct_reg; sg = grp_reg; sd = dig_reg;
        se = eli_reg;  so = oct_reg; good = 1'b1;
        if (pct_reg != PCT_NONE) begin
            if (!k.hex) good = 1'b0;
            else sp = (pct_reg == PCT_TWO) ? PCT_ONE : PCT_NONE;
        end else begin
            unique case (base_reg)
                ST_SCHEME_FIRST: begin
                    if (k.alpha) sb = ST_SCHEME; else good = 1'b0;
                end
                ST_SCHEME: begin
                    priority if (k.alpha || k.digit || c == "+" || c == "-" || c == ".") ;
                    else if (c == ":") sb = ST_AFTER_COLON;
                    else good = 1'b0;
                end
                ST_AFTER_COLON, ST_SLASH1: begin
                    priority if (c == "/")
                        sb = (base_reg == ST_AFTER_COLON) ? ST_SLASH1 : ST_AUTH_START;
                    else if (endf) sb = ends;
                    else if (c == "%") begin sb = ST_PATH; sp = PCT_TWO; end
                    else if (pch) sb = ST_PATH;
                    else good = 1'b0;
                end
                ST_PATH: begin
                    priority if (endf) sb = ends;
                    else if (c == "%") sp = PCT_TWO;
                    else if (!pch) good = 1'b0;
                end
                ST_QUERY: begin
                    priority if (c == "#") sb = ST_FRAG;
                    else if (c == "/" || c == "?") ;
                    else if (c == "%") sp = PCT_TWO;
                    else if (!pch) good = 1'b0;
                end
                ST_FRAG: begin
                    priority if (c == "/" || c == "?") ;
                    else if (c == "%") sp = PCT_TWO;
                    else if (!pch) good = 1'b0;
                end
                ST_AUTH_START, ST_AUTH_PRE: begin
                    priority if (c == "[" && base_reg == ST_AUTH_START) sb = ST_V6_START;
                    else if (c == ":") sb = ST_AUTH_PRE_PORT;
                    else if (c == "@") sb = ST_HOST_START;
                    else if (endf) sb = ends;
                    else if (c == "%") begin sb = ST_AUTH_PRE; sp = PCT_TWO; end
                    else if (k.unres || k.sub) sb = ST_AUTH_PRE;
                    else good = 1'b0;
                end
                ST_AUTH_PRE_PORT: begin
                    priority if (k.digit) ;
                    else if (c == "@") sb = ST_HOST_START;
                    else if (endf) sb = ends;
                    else if (c == "%") begin sb = ST_AUTH_PRE_BAD; sp = PCT_TWO; end
                    else if (k.unres || k.sub || c == ":") sb = ST_AUTH_PRE_BAD;
                    else good = 1'b0;
                end
                ST_AUTH_PRE_BAD: begin
                    priority if (c == "@") sb = ST_HOST_START;
                    else if (c == "%") sp = PCT_TWO;
                    else if (!(k.unres || k.sub || c == ":")) good = 1'b0;
                end
                ST_HOST_START, ST_HOST_REG: begin
                    priority if (c == "[" && base_reg == ST_HOST_START) sb = ST_V6_START;
                    else if (c == ":") sb = ST_PORT;
                    else if (endf) sb = ends;
                    else if (c == "%") begin sb = ST_HOST_REG; sp = PCT_TWO; end
                    else if (k.unres || k.sub) sb = ST_HOST_REG;
                    else good = 1'b0;
                end
                ST_PORT: begin
                    priority if (k.digit) ;
                    else if (endf) sb = ends;
                    else good = 1'b0;
                end
                ST_IP_CLOSE: begin
                    priority if (c == ":") sb = ST_PORT;
                    else if (endf) sb = ends;
                    else good = 1'b0;
                end
                ST_V6_START: begin
                    priority if (c == ":") sb = ST_V6_LEAD;
                    else if (c == "v" || c == "V") sb = ST_FUT_V;
                    else if (k.hex) begin
                        sd = 3'd1; so = oct_step(OCT_EMPTY, c); sb = ST_V6_GROUP;
                    end
                    else good = 1'b0;
                end
                ST_V6_LEAD: begin
                    if (c == ":") begin se = 1'b1; sb = ST_V6_ELIDED; end
                    else good = 1'b0;
                end
                ST_V6_GROUP: begin
                    priority if (k.hex) begin
                        if (dig_reg >= 3'd4) good = 1'b0;
                        else begin sd = dig_reg + 3'd1; so = oct_step(oct_reg, c); end
                    end else if (c == ":") begin
                        sg = grp_reg + 4'd1;
                        if (sg >= 4'd8) good = 1'b0; else sb = ST_V6_COLON;
                    end else if (c == "]") begin
                        sg = grp_reg + 4'd1;
                        sb = ST_IP_CLOSE;
                        good = eli_reg ? (sg <= 4'd7) : (sg == 4'd8);
                    end else if (c == ".") begin
                        if (oct_reg == OCT_EMPTY || oct_reg == OCT_BAD || grp_reg > 4'd6)
                            good = 1'b0;
                        else begin sd = 3'd1; so = OCT_EMPTY; sb = ST_V6_V4; end
                    end else good = 1'b0;
                end
                ST_V6_COLON: begin
                    priority if (c == ":") begin
                        if (eli_reg) good = 1'b0;
                        else begin se = 1'b1; sb = ST_V6_ELIDED; end
                    end else if (k.hex) begin
                        sd = 3'd1; so = oct_step(OCT_EMPTY, c); sb = ST_V6_GROUP;
                    end else good = 1'b0;
                end
                ST_V6_ELIDED: begin
                    priority if (k.hex) begin
                        sd = 3'd1; so = oct_step(OCT_EMPTY, c); sb = ST_V6_GROUP;
                    end else if (c == "]") begin
                        sb = ST_IP_CLOSE;
                        good = eli_reg ? (grp_reg <= 4'd7) : (grp_reg == 4'd8);
                    end else good = 1'b0;
                end
                ST_V6_V4: begin
                    priority if (k.digit) begin
                        so = oct_step(oct_reg, c);
                        good = (so != OCT_BAD);
                    end else if (c == ".") begin
                        if (oct_reg == OCT_EMPTY || dig_reg >= 3'd3) good = 1'b0;
                        else begin sd = dig_reg + 3'd1; so = OCT_EMPTY; end
                    end else if (c == "]") begin
                        if (oct_reg == OCT_EMPTY || dig_reg != 3'd3) good = 1'b0;
                        else begin
                            sg = grp_reg + 4'd2;
                            sb = ST_IP_CLOSE;
                            good = eli_reg ? (sg <= 4'd7) : (sg == 4'd8);
                        end
                    end else good = 1'b0;
                end
                ST_FUT_V: begin
                    if (k.hex) sb = ST_FUT_HEX; else good = 1'b0;
                end
                ST_FUT_HEX: begin
                    priority if (k.hex) ;
                    else if (c == ".") sb = ST_FUT_DOT;
                    else good = 1'b0;
                end
                ST_FUT_DOT, ST_FUT_BODY: begin
                    priority if (k.unres || k.sub || c == ":") sb = ST_FUT_BODY;
                    else if (c == "]" && base_reg == ST_FUT_BODY) sb = ST_IP_CLOSE;
                    else good = 1'b0;
                end
                default: good = 1'b0;
            endcase
        end
    end

    // next state: hold when rejected, clear after the last byte
    always_comb begin
        base_next = base_reg; pct_next = pct_reg; grp_next = grp_reg;
        dig_next = dig_reg; eli_next = eli_reg; oct_next = oct_reg; rej_next = rej_reg;
        if (in_item.valid) begin
            if (!rej_reg) begin
                base_next = sb; pct_next = sp; grp_next = sg;
                dig_next = sd; eli_next = se; oct_next = so;
                rej_next = !good;
            end
            if (in_item.last) begin
                base_next = ST_SCHEME_FIRST; pct_next = PCT_NONE; grp_next = 4'd0;
                dig_next = 3'd0; eli_next = 1'b0; oct_next = OCT_EMPTY; rej_next = 1'b0;
            end
        end
    end

    // result for the last byte
    always_comb begin
        gstate_t fb;
        fb  = rej_reg ? base_reg : sb;
        acc = (rej_reg ? pct_reg : sp) == PCT_NONE &&
              (fb == ST_AFTER_COLON || fb == ST_SLASH1 || fb == ST_AUTH_START ||
               fb == ST_AUTH_PRE || fb == ST_AUTH_PRE_PORT || fb == ST_HOST_START ||
               fb == ST_HOST_REG || fb == ST_PORT || fb == ST_IP_CLOSE ||
               fb == ST_PATH || fb == ST_QUERY || fb == ST_FRAG);
        res_fire = en && in_item.valid && in_item.last;
        res_ok   = !rej_reg && good && acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= ST_SCHEME_FIRST;
            pct_reg  <= PCT_NONE;
            grp_reg  <= 4'd0;
            dig_reg  <= 3'd0;
            eli_reg  <= 1'b0;
            oct_reg  <= OCT_EMPTY;
            rej_reg  <= 1'b0;
        end else if (en) begin
            base_reg <= base_next;
            pct_reg  <= pct_next;
            grp_reg  <= grp_next;
            dig_reg  <= dig_next;
            eli_reg  <= eli_next;
            oct_reg  <= oct_next;
            rej_reg  <= rej_next;
        end
    end

`ifndef SYNTHESIS
    a_pct_code: assert property (@(posedge aclk) disable iff (!aresetn)
        pct_reg != 2'd3) else $error("bad escape progress");
    a_dig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dig_reg <= 3'd4) else $error("hex digit count overflow");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> (base_reg == ST_SCHEME_FIRST && !rej_reg && !eli_reg))
        else $error("state not cleared after last byte");
    a_grp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_reg <= 4'd8) else $error("group count overflow");
`endif
endmodule

/* sv/uri_syntax_validator_top.sv */
// A last byte is registered in the class cell; its verdict, in the m_tvalid register.
// Throughput: one byte per cycle unless stalled; grammar state updates only with en.
// Backpressure stalls the whole chain only while a result waits in the output register.
// Reset: aresetn low at a clock edge clears the grammar state, the sticky reject
// flag and all valid bits; the block is ready again in the next cycle.
module uri_syntax_validator_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] uri_ok, [7:1] zero
);
    import uv_pkg::*;

    citem_t cls_item;
    logic   en;
    logic   res_fire;
    logic   res_ok;
    logic   m_valid_reg;
    logic   m_ok_reg;

    // advance the chain whenever the output slot is free or being drained
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // first cell: classify the byte
    uv_class_cell u_class (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_chr   (s_tdata),
        .in_last  (s_tlast),
        .out_item (cls_item)
    );

    // second cell: grammar state update and verdict
    uv_step_cell u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_item  (cls_item),
        .res_fire (res_fire),
        .res_ok   (res_ok)
    );

    // output register: load a verdict, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= res_fire;
        end
        if (res_fire) begin
            m_ok_reg <= res_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_ok_reg};

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped under backpressure");
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("stall without pending result");
    a_fire_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> m_tvalid) else $error("verdict not presented");
`endif
endmodule
